@@ rtl/assert_macros.svh @@
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CAV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define CAV_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/cav_pkg.sv @@
// shared types and constants of the covariance absolute value detector
package cav_pkg;

	localparam int unsigned SAMPLE_BITS = 16;
	localparam int unsigned ACC_W       = 48;
	localparam int unsigned PWR_W       = 56;
	localparam int unsigned ALPHA_W     = 24;
	localparam int unsigned THR_W       = 16;
	localparam int unsigned MAG_W       = 49;
	localparam int unsigned SQ_W        = 98;
	localparam int unsigned SUM_W       = 64;
	localparam int unsigned M_W         = 32;

	// defaults of the top level parameters
	localparam int unsigned MAX_LAGS_DEF     = 16;
	localparam int unsigned MAX_BLOCK_DEF    = 4096;
	localparam int unsigned READY_BLOCKS_DEF = 50;

	// apb port
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// register indexes
	localparam logic [2:0] REG_LAG_COUNT  = 3'd0;
	localparam logic [2:0] REG_BLOCK_LEN  = 3'd1;
	localparam logic [2:0] REG_THRESHOLD  = 3'd2;
	localparam logic [2:0] REG_EWMA_ALPHA = 3'd3;
	localparam logic [2:0] REG_SNR_ENABLE = 3'd4;

	// register reset values
	localparam logic [4:0]         LAG_COUNT_RST  = 5'd8;
	localparam logic [12:0]        BLOCK_LEN_RST  = 13'd1024;
	localparam logic [THR_W-1:0]   THRESHOLD_RST  = 16'd4915;
	localparam logic [ALPHA_W-1:0] EWMA_ALPHA_RST = 24'd1678;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_i;
		logic signed [SAMPLE_BITS-1:0] sample_q;
	} in_t;

	typedef struct packed {
		logic             detected;
		logic             noise_ready;
		logic [PWR_W-1:0] noise_power;
		logic [PWR_W-1:0] signal_noise_power;
	} out_t;

	// control that the sequencer broadcasts to every lag cell
	typedef struct packed {
		logic load;
		logic mul;
		logic acc;
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

@@ rtl/cav_stream_if.sv @@
// valid/ready stream channel carrying one payload
interface cav_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/covariance_absolute_value_detector_top.sv @@
// top level of the covariance absolute value detector: apb registers, lag cells, sequencer
// a sample passes accept, power square, ewma products and ewma update in turn
// the last sample of a block then runs each lag through load, magnitude (6 square steps,
// 49 root steps) and weight, and then through the threshold test
// the result goes to an output register, so the next sample is taken while it waits
// arst_n clears history, accumulators, counters, power estimates and registers to defaults
`include "assert_macros.svh"

module covariance_absolute_value_detector_top #(
	parameter int unsigned MAX_LAGS     = cav_pkg::MAX_LAGS_DEF,
	parameter int unsigned MAX_BLOCK    = cav_pkg::MAX_BLOCK_DEF,
	parameter int unsigned READY_BLOCKS = cav_pkg::READY_BLOCKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cav_pkg::ADDR_W-1:0]   paddr,
	input  logic [cav_pkg::DATA_W-1:0]   pwdata,
	output logic [cav_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	cav_stream_if.sink                   samples,
	cav_stream_if.source                 results
);
	localparam int unsigned SB  = cav_pkg::SAMPLE_BITS;
	localparam int unsigned AW  = cav_pkg::ACC_W;
	localparam int unsigned PW  = cav_pkg::PWR_W;
	localparam int unsigned ALW = cav_pkg::ALPHA_W;
	localparam int unsigned TW  = cav_pkg::THR_W;
	localparam int unsigned MW  = cav_pkg::MAG_W;
	localparam int unsigned SW  = cav_pkg::SUM_W;
	localparam int unsigned MSW = cav_pkg::M_W;
	localparam int unsigned LW  = $clog2(MAX_LAGS + 1);
	localparam int unsigned LI  = $clog2(MAX_LAGS);
	localparam int unsigned CW  = $clog2(MAX_BLOCK + 1);
	localparam int unsigned NBW = $clog2(READY_BLOCKS + 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SQ   = 9'b000000010,
		S_MUL  = 9'b000000100,
		S_ADD  = 9'b000001000,
		S_LOAD = 9'b000010000,
		S_WAIT = 9'b000100000,
		S_THR1 = 9'b001000000,
		S_THR2 = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	// configuration registers
	logic [4:0]     lag_count_q;
	logic [12:0]    block_length_q;
	logic [TW-1:0]  threshold_q;
	logic [ALW-1:0] alpha_q;
	logic           snr_enable_q;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_count_q    <= cav_pkg::LAG_COUNT_RST;
			block_length_q <= cav_pkg::BLOCK_LEN_RST;
			threshold_q    <= cav_pkg::THRESHOLD_RST;
			alpha_q        <= cav_pkg::EWMA_ALPHA_RST;
			snr_enable_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				cav_pkg::REG_LAG_COUNT:  lag_count_q    <= pwdata[4:0];
				cav_pkg::REG_BLOCK_LEN:  block_length_q <= pwdata[12:0];
				cav_pkg::REG_THRESHOLD:  threshold_q    <= pwdata[TW-1:0];
				cav_pkg::REG_EWMA_ALPHA: alpha_q        <= pwdata[ALW-1:0];
				cav_pkg::REG_SNR_ENABLE: snr_enable_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[4:2])
			cav_pkg::REG_LAG_COUNT:  prdata = 32'(lag_count_q);
			cav_pkg::REG_BLOCK_LEN:  prdata = 32'(block_length_q);
			cav_pkg::REG_THRESHOLD:  prdata = 32'(threshold_q);
			cav_pkg::REG_EWMA_ALPHA: prdata = 32'(alpha_q);
			cav_pkg::REG_SNR_ENABLE: prdata = 32'(snr_enable_q);
			default:                 prdata = '0;
		endcase
	end

	// clamped lag count and block length
	logic [LW-1:0] l_eff;
	logic [CW-1:0] n_eff;

	always_comb begin
		if (lag_count_q == 5'd0) begin
			l_eff = LW'(1);
		end else if (32'(lag_count_q) > MAX_LAGS) begin
			l_eff = LW'(MAX_LAGS);
		end else begin
			l_eff = LW'(lag_count_q);
		end
		if (block_length_q == 13'd0) begin
			n_eff = CW'(1);
		end else if (32'(block_length_q) > MAX_BLOCK) begin
			n_eff = CW'(MAX_BLOCK);
		end else begin
			n_eff = CW'(block_length_q);
		end
	end

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic [LI-1:0]       lag_q;
	logic [NBW-1:0]      nb_q;
	logic [PW-1:0]       nreg_q, npend_q, sreg_q, spend_q;
	logic                out_valid_q;
	cav_pkg::out_t       out_q;
	cav_pkg::in_t        x_q;
	logic [MSW-1:0]      m_q;
	logic [PW-1:0]       dnh_q, dsh_q;
	logic [ALW-1:0]      dnl_q, dsl_q;
	logic [MSW-1:0]      ih_q;
	logic [2*ALW-1:0]    il_q;
	logic [MW-1:0]       r0_q;
	logic [SW-1:0]       s_q, c_q, a_q, bh_q;
	logic [TW-1:0]       bl_q;

	logic                accept, last_sample, last_lag, fire, det;
	logic [CW-1:0]       cnt_nx;
	cav_pkg::cell_ctl_t  ctl;
	logic                mag_busy, mag_done;
	logic [MW-1:0]       mag_val;
	logic [LW-1:0]       weight;
	logic [MW+LW-1:0]    wprod, cprod;
	logic [TW+SW-13:0]   bhp;
	logic [TW+11:0]      blp;
	logic [PW-1:0]       pn, ps, nupd, supd;
	logic [2*ALW-1:0]    pnl, psl;
	logic signed [2*SB:0] msq;
	logic [PW-1:0]       nreg_nx, sreg_nx;
	logic [NBW-1:0]      nb_nx;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign cnt_nx        = cnt_q + CW'(1);
	assign last_sample   = (cnt_nx >= n_eff);
	assign last_lag      = ((32'(lag_q) + 32'd1) == 32'(l_eff));
	assign fire          = (state_q == S_DONE) && (!out_valid_q || results.ready);

	// cell control
	always_comb begin
		ctl.load  = accept;
		ctl.mul   = (state_q == S_SQ);
		ctl.acc   = (state_q == S_MUL);
		ctl.shift = (state_q == S_WAIT) && mag_done && !last_lag;
		ctl.clear = fire;
	end

	// chain of lag cells
	logic [2*SB-1:0] hist_w [0:MAX_LAGS];
	logic [AW-1:0]   re_w   [0:MAX_LAGS];
	logic [AW-1:0]   im_w   [0:MAX_LAGS];

	assign hist_w[0]        = {samples.data.sample_q, samples.data.sample_i};
	assign re_w[MAX_LAGS]   = '0;
	assign im_w[MAX_LAGS]   = '0;

	for (genvar l = 0; l < MAX_LAGS; l++) begin : g_cell
		cav_pkg::cell_ctl_t cell_ctl;

		// only the lags in use accumulate
		always_comb begin
			cell_ctl     = ctl;
			cell_ctl.acc = ctl.acc && (32'(l) < 32'(l_eff));
		end

		cav_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.x         (x_q),
			.prev_hist (hist_w[l]),
			.hist      (hist_w[l+1]),
			.next_re   (re_w[l+1]),
			.next_im   (im_w[l+1]),
			.acc_re    (re_w[l]),
			.acc_im    (im_w[l])
		);
	end

	// magnitude unit reads lag sums from the head of the chain
	cav_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LOAD),
		.re     (re_w[0]),
		.im     (im_w[0]),
		.busy   (mag_busy),
		.done   (mag_done),
		.mag    (mag_val)
	);

	// ewma finishing step, saturating
	function automatic logic [PW-1:0] ewma_fin(
		input logic [PW-1:0]      p,
		input logic [PW-1:0]      dh,
		input logic [ALW-1:0]     dl,
		input logic [MSW-1:0]     ih,
		input logic [2*ALW-1:0]   il
	);
		logic [PW:0]   dec;
		logic [PW-1:0] pd;
		logic [PW+1:0] inc, r;
		dec = (PW+1)'(dh) + (PW+1)'(dl);
		pd  = p - PW'(dec);
		inc = ((PW+2)'(ih) << ALW) + (PW+2)'(il);
		r   = (PW+2)'(pd) + inc;
		return (r[PW+1:PW] != 2'b00) ? {PW{1'b1}} : PW'(r);
	endfunction

	// power and decision arithmetic
	assign msq    = x_q.sample_i * x_q.sample_i + x_q.sample_q * x_q.sample_q;
	assign pn     = (cnt_q == '0) ? nreg_q : npend_q;
	assign ps     = (cnt_q == '0) ? sreg_q : spend_q;
	assign pnl    = alpha_q * pn[ALW-1:0];
	assign psl    = alpha_q * ps[ALW-1:0];
	assign nupd   = ewma_fin(npend_q, dnh_q, dnl_q, ih_q, il_q);
	assign supd   = ewma_fin(spend_q, dsh_q, dsl_q, ih_q, il_q);
	assign weight = LW'(32'(l_eff) - 32'(lag_q));
	assign wprod  = weight * mag_val;
	assign cprod  = l_eff * r0_q;
	assign bhp    = threshold_q * c_q[SW-1:12];
	assign blp    = threshold_q * c_q[11:0];
	assign det    = a_q > (bh_q + SW'(bl_q));

	// block commit
	always_comb begin
		nreg_nx = nreg_q;
		sreg_nx = sreg_q;
		nb_nx   = nb_q;
		if (det) begin
			if (snr_enable_q && (32'(nb_q) >= READY_BLOCKS)) begin
				sreg_nx = spend_q;
			end
		end else begin
			nreg_nx = npend_q;
			if (32'(nb_q) < READY_BLOCKS) begin
				nb_nx = nb_q + NBW'(1);
			end
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			lag_q       <= '0;
			nb_q        <= '0;
			nreg_q      <= '0;
			npend_q     <= '0;
			sreg_q      <= '0;
			spend_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_MUL;
				S_MUL: begin
					npend_q <= pn;
					spend_q <= ps;
					state_q <= S_ADD;
				end
				S_ADD: begin
					npend_q <= nupd;
					spend_q <= supd;
					if (last_sample) begin
						cnt_q   <= '0;
						lag_q   <= '0;
						state_q <= S_LOAD;
					end else begin
						cnt_q   <= cnt_nx;
						state_q <= S_IDLE;
					end
				end
				S_LOAD: state_q <= S_WAIT;
				S_WAIT: begin
					if (mag_done) begin
						if (last_lag) begin
							state_q <= S_THR1;
						end else begin
							lag_q   <= lag_q + LI'(1);
							state_q <= S_LOAD;
						end
					end
				end
				S_THR1: state_q <= S_THR2;
				S_THR2: state_q <= S_DONE;
				S_DONE: begin
					if (fire) begin
						nreg_q      <= nreg_nx;
						sreg_q      <= sreg_nx;
						nb_q        <= nb_nx;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= samples.data;
		end
		if (state_q == S_SQ) begin
			m_q <= msq[MSW-1:0];
		end
		if (state_q == S_MUL) begin
			dnh_q <= alpha_q * pn[PW-1:ALW];
			dsh_q <= alpha_q * ps[PW-1:ALW];
			dnl_q <= pnl[2*ALW-1:ALW];
			dsl_q <= psl[2*ALW-1:ALW];
			ih_q  <= alpha_q * m_q[MSW-1:ALW];
			il_q  <= alpha_q * m_q[ALW-1:0];
		end
		if ((state_q == S_ADD) && last_sample) begin
			s_q <= '0;
		end
		if ((state_q == S_WAIT) && mag_done) begin
			if (lag_q == '0) begin
				r0_q <= mag_val;
			end else begin
				s_q <= s_q + SW'(wprod);
			end
		end
		if (state_q == S_THR1) begin
			c_q <= SW'(cprod);
		end
		if (state_q == S_THR2) begin
			bh_q <= SW'(bhp);
			bl_q <= blp[TW+11:12];
			a_q  <= c_q + (s_q << 1);
		end
		if (fire) begin
			out_q.detected           <= det;
			out_q.noise_ready        <= (32'(nb_nx) >= READY_BLOCKS);
			out_q.noise_power        <= nreg_nx;
			out_q.signal_noise_power <= sreg_nx;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	// checks
	`CAV_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result without block end")
	`CAV_ASSERT(a_lag_in_range, (state_q == S_LOAD) |-> (32'(lag_q) < 32'(l_eff)), "lag beyond lag count")
	`CAV_NEVER(a_mag_restart, (state_q == S_LOAD) && mag_busy, "magnitude unit started while busy")
	`CAV_ASSERT(a_noise_count, 32'(nb_q) <= READY_BLOCKS, "noise block count overrun")
endmodule

@@ rtl/cav_cell.sv @@
// one lag cell: history tap and complex correlation accumulator
module cav_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cav_pkg::cell_ctl_t                  ctl,
	input  cav_pkg::in_t                        x,
	input  logic [2*cav_pkg::SAMPLE_BITS-1:0]   prev_hist,
	output logic [2*cav_pkg::SAMPLE_BITS-1:0]   hist,
	input  logic [cav_pkg::ACC_W-1:0]           next_re,
	input  logic [cav_pkg::ACC_W-1:0]           next_im,
	output logic [cav_pkg::ACC_W-1:0]           acc_re,
	output logic [cav_pkg::ACC_W-1:0]           acc_im
);
	localparam int unsigned SB = cav_pkg::SAMPLE_BITS;
	localparam int unsigned PW = 2 * SB + 1;

	logic [2*SB-1:0]          hist_q;
	logic [cav_pkg::ACC_W-1:0] re_q, im_q;
	logic signed [PW-1:0]     pre_q, pim_q;
	logic signed [PW-1:0]     pre, pim;
	logic signed [SB-1:0]     yi, yq;

	assign yi = hist_q[SB-1:0];
	assign yq = hist_q[2*SB-1:SB];

	// x times conj of the lagged sample
	assign pre = x.sample_i * yi + x.sample_q * yq;
	assign pim = x.sample_q * yi - x.sample_i * yq;

	// history tap and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			re_q   <= '0;
			im_q   <= '0;
		end else begin
			if (ctl.load) begin
				hist_q <= prev_hist;
			end
			if (ctl.clear) begin
				re_q <= '0;
				im_q <= '0;
			end else if (ctl.shift) begin
				re_q <= next_re;
				im_q <= next_im;
			end else if (ctl.acc) begin
				re_q <= re_q + cav_pkg::ACC_W'(pre_q);
				im_q <= im_q + cav_pkg::ACC_W'(pim_q);
			end
		end
	end

	// product register
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			pre_q <= pre;
			pim_q <= pim;
		end
	end

	assign hist   = hist_q;
	assign acc_re = re_q;
	assign acc_im = im_q;
endmodule

@@ rtl/cav_mag.sv @@
// floor magnitude of a complex 48-bit sum: squares by partial products, then bitwise root
module cav_mag (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cav_pkg::ACC_W-1:0]    re,
	input  logic [cav_pkg::ACC_W-1:0]    im,
	output logic                         busy,
	output logic                         done,
	output logic [cav_pkg::MAG_W-1:0]    mag
);
	localparam int unsigned AW = cav_pkg::ACC_W;
	localparam int unsigned HW = AW / 2;
	localparam int unsigned QW = cav_pkg::SQ_W;
	localparam int unsigned MW = cav_pkg::MAG_W;
	localparam int unsigned RW = MW + 2;
	localparam int unsigned SQ_STEPS = 6;

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_SQ   = 3'b010,
		M_ROOT = 3'b100
	} mstate_t;

	mstate_t         state_q;
	logic [5:0]      step_q;
	logic            done_q;
	logic [AW-1:0]   a_q, b_q;
	logic [QW-1:0]   rad_q;
	logic [RW-1:0]   rem_q;
	logic [MW-1:0]   root_q;
	logic [AW-1:0]   abs_re, abs_im;
	logic [HW-1:0]   op1, op2;
	logic [2*HW-1:0] prod;
	logic [QW-1:0]   term;
	logic [RW+1:0]   rem_n, trial;

	assign abs_re = re[AW-1] ? (~re + AW'(1)) : re;
	assign abs_im = im[AW-1] ? (~im + AW'(1)) : im;

	// partial product of the current squaring step
	always_comb begin
		op1  = a_q[AW-1:HW];
		op2  = a_q[AW-1:HW];
		case (step_q)
			6'd0: begin op1 = a_q[AW-1:HW]; op2 = a_q[AW-1:HW]; end
			6'd1: begin op1 = a_q[AW-1:HW]; op2 = a_q[HW-1:0]; end
			6'd2: begin op1 = a_q[HW-1:0];  op2 = a_q[HW-1:0]; end
			6'd3: begin op1 = b_q[AW-1:HW]; op2 = b_q[AW-1:HW]; end
			6'd4: begin op1 = b_q[AW-1:HW]; op2 = b_q[HW-1:0]; end
			default: begin op1 = b_q[HW-1:0]; op2 = b_q[HW-1:0]; end
		endcase
		prod = op1 * op2;
		case (step_q)
			6'd0, 6'd3: term = QW'(prod) << AW;
			6'd1, 6'd4: term = QW'(prod) << (HW + 1);
			default:    term = QW'(prod);
		endcase
	end

	// one root digit
	assign rem_n = {rem_q, rad_q[QW-1:QW-2]};
	assign trial = {2'b00, root_q, 2'b01};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_SQ;
						step_q  <= '0;
					end
				end
				M_SQ: begin
					if (step_q == 6'(SQ_STEPS - 1)) begin
						state_q <= M_ROOT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				M_ROOT: begin
					if (step_q == 6'(MW - 1)) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				a_q    <= abs_re;
				b_q    <= abs_im;
				rad_q  <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end
			M_SQ: begin
				rad_q <= rad_q + term;
			end
			M_ROOT: begin
				rad_q <= rad_q << 2;
				if (rem_n >= trial) begin
					rem_q  <= RW'(rem_n - trial);
					root_q <= {root_q[MW-2:0], 1'b1};
				end else begin
					rem_q  <= RW'(rem_n);
					root_q <= {root_q[MW-2:0], 1'b0};
				end
			end
			default: rad_q <= rad_q;
		endcase
	end

	assign busy = (state_q != M_IDLE);
	assign done = done_q;
	assign mag  = root_q;
endmodule

@@ bench/tb_top.sv @@
// testbench of the covariance absolute value detector with a bit-exact scoreboard
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_LAGS  = cav_pkg::MAX_LAGS_DEF;
	localparam int unsigned NUM_BLOCK = cav_pkg::MAX_BLOCK_DEF;
	localparam int unsigned READY_CNT = cav_pkg::READY_BLOCKS_DEF;
	localparam int unsigned LIMIT     = 10000000;
	localparam int unsigned SETTLE    = 1200;
	localparam logic [cav_pkg::PWR_W-1:0] PWR_SAT = '1;

	// sample content kinds of one block
	typedef enum int {
		KIND_NOISE,
		KIND_LOW_NOISE,
		KIND_CONST,
		KIND_TONE,
		KIND_ZERO
	} content_t;

	// bit-exact model of the detector with its own registers and state
	class scoreboard_t;
		logic [31:0]               lag_hist[NUM_LAGS];
		logic [cav_pkg::ACC_W-1:0] sum_re[NUM_LAGS];
		logic [cav_pkg::ACC_W-1:0] sum_im[NUM_LAGS];
		int unsigned               fill;
		logic [cav_pkg::PWR_W-1:0] noise_pwr, noise_run, sig_pwr, sig_run;
		int unsigned               noise_blocks;
		int unsigned               lag_cfg, len_cfg, thr_cfg, alpha_cfg, snr_cfg;
		cav_pkg::out_t             pending_q[$];
		int unsigned               errors;

		function new();
			foreach (lag_hist[k]) begin
				lag_hist[k] = '0;
				sum_re[k] = '0;
				sum_im[k] = '0;
			end
			fill = 0;
			noise_pwr = '0;
			noise_run = '0;
			sig_pwr = '0;
			sig_run = '0;
			noise_blocks = 0;
			lag_cfg = 32'(cav_pkg::LAG_COUNT_RST);
			len_cfg = 32'(cav_pkg::BLOCK_LEN_RST);
			thr_cfg = 32'(cav_pkg::THRESHOLD_RST);
			alpha_cfg = 32'(cav_pkg::EWMA_ALPHA_RST);
			snr_cfg = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				cav_pkg::REG_LAG_COUNT: begin
					lag_cfg = 32'(val[4:0]);
				end
				cav_pkg::REG_BLOCK_LEN: begin
					len_cfg = 32'(val[12:0]);
				end
				cav_pkg::REG_THRESHOLD: begin
					thr_cfg = 32'(val[15:0]);
				end
				cav_pkg::REG_EWMA_ALPHA: begin
					alpha_cfg = 32'(val[23:0]);
				end
				cav_pkg::REG_SNR_ENABLE: begin
					snr_cfg = 32'(val[0]);
				end
				default: ;
			endcase
		endfunction

		static function logic [cav_pkg::MAG_W-1:0] abs48(logic [cav_pkg::ACC_W-1:0] v);
			longint sv;
			sv = longint'(signed'(v));
			return (sv < 0) ? cav_pkg::MAG_W'(-sv) : cav_pkg::MAG_W'(sv);
		endfunction

		// floor of the complex magnitude by a bitwise root
		static function logic [cav_pkg::MAG_W-1:0] magnitude(logic [cav_pkg::ACC_W-1:0] re,
				logic [cav_pkg::ACC_W-1:0] im);
			logic [cav_pkg::SQ_W-1:0]  a, b, tot, sq;
			logic [cav_pkg::MAG_W-1:0] root, cand;
			a = cav_pkg::SQ_W'(abs48(re));
			b = cav_pkg::SQ_W'(abs48(im));
			tot = a * a + b * b;
			root = '0;
			for (int k = cav_pkg::MAG_W - 1; k >= 0; k--) begin
				cand = root | (cav_pkg::MAG_W'(1) << k);
				sq = cav_pkg::SQ_W'(cand) * cav_pkg::SQ_W'(cand);
				if (sq <= tot)
					root = cand;
			end
			return root;
		endfunction

		// one q24 averaging step, saturating
		static function logic [cav_pkg::PWR_W-1:0] average(logic [cav_pkg::PWR_W-1:0] p,
				logic [63:0] m, int unsigned alpha);
			logic [127:0] al, dec, hi, inc, r;
			al = 128'(alpha);
			dec = al * 128'(p >> 24) + ((al * 128'(p[23:0])) >> 24);
			hi = al * 128'(m >> 24);
			if (hi >= (128'd1 << 32))
				return PWR_SAT;
			inc = (hi << 24) + al * 128'(m[23:0]);
			r = 128'(p) - dec + inc;
			return (r > 128'(PWR_SAT)) ? PWR_SAT : r[cav_pkg::PWR_W-1:0];
		endfunction

		function void note_sample(cav_pkg::in_t s);
			int unsigned      lags, len;
			longint           xi, xq, yi, yq;
			logic [63:0]      pwr;
			logic [127:0]     r0, wsum, c, a, b;
			cav_pkg::out_t    res;
			lags = (lag_cfg < 1) ? 1 : (lag_cfg > NUM_LAGS) ? NUM_LAGS : lag_cfg;
			len = (len_cfg < 1) ? 1 : (len_cfg > NUM_BLOCK) ? NUM_BLOCK : len_cfg;
			xi = longint'(s.sample_i);
			xq = longint'(s.sample_q);
			if (fill == 0) begin
				noise_run = noise_pwr;
				sig_run = sig_pwr;
			end
			// lag products against the carried history
			for (int l = 0; l < lags; l++) begin
				yi = xi;
				yq = xq;
				if (l > 0) begin
					yi = longint'(signed'(lag_hist[l-1][15:0]));
					yq = longint'(signed'(lag_hist[l-1][31:16]));
				end
				sum_re[l] = sum_re[l] + cav_pkg::ACC_W'(xi * yi + xq * yq);
				sum_im[l] = sum_im[l] + cav_pkg::ACC_W'(xq * yi - xi * yq);
			end
			for (int l = NUM_LAGS - 1; l > 0; l--)
				lag_hist[l] = lag_hist[l-1];
			lag_hist[0] = {s.sample_q, s.sample_i};
			pwr = 64'(xi * xi + xq * xq);
			noise_run = average(noise_run, pwr, alpha_cfg);
			sig_run = average(sig_run, pwr, alpha_cfg);
			fill++;
			if (fill < len)
				return;
			// end of block: threshold test
			r0 = 128'(magnitude(sum_re[0], sum_im[0]));
			wsum = '0;
			for (int l = 1; l < lags; l++)
				wsum += 128'(lags - l) * 128'(magnitude(sum_re[l], sum_im[l]));
			c = 128'(lags) * r0;
			a = c + 2 * wsum;
			b = 128'(thr_cfg) * (c >> 12) + ((128'(thr_cfg) * (c & 128'd4095)) >> 12);
			res.detected = (a > b);
			if (res.detected) begin
				if (snr_cfg != 0 && noise_blocks >= READY_CNT)
					sig_pwr = sig_run;
			end else begin
				noise_pwr = noise_run;
				if (noise_blocks < READY_CNT)
					noise_blocks++;
			end
			foreach (sum_re[k]) begin
				sum_re[k] = '0;
				sum_im[k] = '0;
			end
			fill = 0;
			res.noise_ready = (noise_blocks >= READY_CNT);
			res.noise_power = noise_pwr;
			res.signal_noise_power = sig_pwr;
			pending_q.push_back(res);
		endfunction

		function void check_result(cav_pkg::out_t got);
			cav_pkg::out_t exp_r;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %p", $realtime, got);
				errors++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.detected !== exp_r.detected) begin
				$display("%0t: detected expected %0b actual %0b", $realtime,
					exp_r.detected, got.detected);
				errors++;
			end
			if (got.noise_ready !== exp_r.noise_ready) begin
				$display("%0t: noise_ready expected %0b actual %0b", $realtime,
					exp_r.noise_ready, got.noise_ready);
				errors++;
			end
			if (got.noise_power !== exp_r.noise_power) begin
				$display("%0t: noise_power expected %0h actual %0h", $realtime,
					exp_r.noise_power, got.noise_power);
				errors++;
			end
			if (got.signal_noise_power !== exp_r.signal_noise_power) begin
				$display("%0t: signal_noise_power expected %0h actual %0h", $realtime,
					exp_r.signal_noise_power, got.signal_noise_power);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        psel, penable, pwrite;
	logic [cav_pkg::ADDR_W-1:0]  paddr;
	logic [cav_pkg::DATA_W-1:0]  pwdata, prdata;
	logic                        pready;
	int unsigned                 cycles;
	int unsigned                 burst_left;
	int unsigned                 stall_mode;
	scoreboard_t                 sb;

	cav_stream_if #(.payload_t(cav_pkg::in_t))  smp_if ();
	cav_stream_if #(.payload_t(cav_pkg::out_t)) res_if ();

	covariance_absolute_value_detector_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (smp_if.sink),
		.results (res_if.source)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// monitors: note each sample transfer and check each result transfer
	always @(posedge clk) begin
		if (arst_n && smp_if.valid && smp_if.ready)
			sb.note_sample(smp_if.data);
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.data);
	end

	// receiver stalls: full speed, random, or long stall stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: res_if.ready = 1'b1;
			1: res_if.ready = ($urandom_range(0, 2) != 0);
			default: res_if.ready = ($urandom_range(0, 15) == 0);
		endcase
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = cav_pkg::ADDR_W'(idx) << 2;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// one sample transfer, with bursts and gaps on the sending side
	task automatic send_sample(int si, int sq);
		if (burst_left == 0) begin
			smp_if.valid = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6))
				@(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		smp_if.valid = 1'b1;
		smp_if.data.sample_i = 16'(si);
		smp_if.data.sample_q = 16'(sq);
		@(posedge clk);
		while (!smp_if.ready)
			@(posedge clk);
		burst_left--;
		@(negedge clk);
		smp_if.valid = 1'b0;
	endtask

	// wait until every expected result has arrived and the block is quiet
	task automatic drain();
		smp_if.valid = 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(int unsigned lags, int unsigned len, int unsigned thr,
			int unsigned alpha, int unsigned snr);
		drain();
		reg_write(cav_pkg::REG_LAG_COUNT, lags);
		reg_write(cav_pkg::REG_BLOCK_LEN, len);
		reg_write(cav_pkg::REG_THRESHOLD, thr);
		reg_write(cav_pkg::REG_EWMA_ALPHA, alpha);
		reg_write(cav_pkg::REG_SNR_ENABLE, snr);
	endtask

	// one run of samples of a given content kind
	task automatic send_run(content_t kind, int unsigned count);
		logic signed [15:0] ci, cq, amp;
		ci = 16'($urandom);
		cq = 16'($urandom);
		amp = 16'($urandom_range(1000, 32767));
		for (int unsigned n = 0; n < count; n++) begin
			case (kind)
				KIND_NOISE: send_sample($urandom, $urandom);
				KIND_LOW_NOISE: send_sample(int'($urandom_range(0, 128)) - 64,
					int'($urandom_range(0, 128)) - 64);
				KIND_CONST: send_sample(ci, cq);
				KIND_TONE: begin
					case (n % 4)
						0: send_sample(amp, 0);
						1: send_sample(0, amp);
						2: send_sample(-amp, 0);
						default: send_sample(0, -amp);
					endcase
				end
				default: send_sample(0, 0);
			endcase
		end
	endtask

	initial begin
		int unsigned sent, lags, len, thr, alpha, blocks;
		content_t    kind;
		sb = new();
		cycles = 0;
		burst_left = 0;
		stall_mode = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp_if.valid = 1'b0;
		smp_if.data = '0;
		res_if.ready = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes in one short block at full lags
		configure(16, 16, 4915, 16777215, 1);
		send_sample(-32768, -32768);
		send_sample(32767, 32767);
		send_sample(-32768, 32767);
		send_sample(32767, -32768);
		send_sample(0, 0);
		send_sample(1, -1);
		send_sample(-1, 1);
		send_sample(16'h5555, -16'sh5556);
		send_sample(-16'sh5556, 16'h5555);
		send_sample(-32768, 0);
		send_sample(0, -32768);
		send_sample(32767, 0);
		send_sample(0, 32767);
		send_sample(-32768, -32768);
		send_sample(-32768, -32768);
		send_sample(-32768, -32768);
		// lag count and block length of zero, zero alpha, a zero block
		configure(0, 0, 0, 0, 0);
		send_sample(0, 0);
		send_sample(-32768, 32767);
		sent = 18;

		// noise blocks at the highest threshold until the noise estimate is ready
		while (sb.noise_blocks < READY_CNT) begin
			configure($urandom_range(1, 16), $urandom_range(16, 32), 65535,
				$urandom_range(1, 16777215), $urandom_range(0, 1));
			blocks = $urandom_range(2, 6);
			for (int unsigned k = 0; k < blocks; k++) begin
				kind = ($urandom_range(0, 5) == 0) ? KIND_ZERO :
					($urandom_range(0, 1) ? KIND_NOISE : KIND_LOW_NOISE);
				send_run(kind, sb.len_cfg);
				sent += sb.len_cfg;
			end
		end

		// random settings with mixed content, partial blocks carried over
		while (sent < 1600) begin
			case ($urandom_range(0, 7))
				0: lags = 0;
				1: lags = 31;
				2: lags = 1;
				3: lags = 16;
				default: lags = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 9))
				0: len = 1;
				1: len = 16;
				default: len = $urandom_range(16, 48);
			endcase
			case ($urandom_range(0, 5))
				0: thr = 0;
				1: thr = 65535;
				2: thr = 4915;
				default: thr = $urandom_range(4096, 20000);
			endcase
			case ($urandom_range(0, 5))
				0: alpha = 1;
				1: alpha = 16777215;
				2: alpha = 1678;
				default: alpha = $urandom_range(1, 16777215);
			endcase
			configure(lags, len, thr, alpha, 32'($urandom_range(0, 3) != 0));
			blocks = $urandom_range(2, 8);
			for (int unsigned k = 0; k < blocks; k++) begin
				kind = content_t'($urandom_range(0, 4));
				send_run(kind, len);
				sent += len;
			end
			if ($urandom_range(0, 2) == 0) begin
				blocks = $urandom_range(1, len);
				send_run(KIND_NOISE, blocks);
				sent += blocks;
			end
		end

		// lengths written above the limit, then shrunk below the count already reached
		configure(31, 8191, 4915, 1678, 1);
		send_run(KIND_TONE, 40);
		configure(31, 16, 4915, 1678, 1);
		send_run(KIND_TONE, 1);

		drain();
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

@@ covariance_absolute_value_detector_top.f @@
+incdir+rtl
rtl/cav_pkg.sv
rtl/cav_stream_if.sv
rtl/cav_cell.sv
rtl/cav_mag.sv
rtl/covariance_absolute_value_detector_top.sv
bench/tb_top.sv
